// ===== rtl/core/eiec_pkg.sv =====
// ----------------------------------------------------------------------------
// ELF image extent check package
// Shared types, constants and header field locations for the extent checker.
// ----------------------------------------------------------------------------
`default_nettype none

package eiec_pkg;

   // Default store depth and reset value of the offset limit register.
   localparam int unsigned STORE_BYTES_DEF    = 65536;
   localparam logic [31:0] OFFSET_LIMIT_RESET = 32'd134217728;

   // Verdict codes.
   localparam logic [2:0] STAT_MATCHED   = 3'd0;
   localparam logic [2:0] STAT_NO_MATCH  = 3'd1;
   localparam logic [2:0] STAT_NEED_MORE = 3'd2;
   localparam logic [2:0] STAT_TRUNC_STR = 3'd3;
   localparam logic [2:0] STAT_TRUNC_IMG = 3'd4;
   localparam logic [2:0] STAT_OVERFLOW  = 3'd5;

   // Signature bytes 7F 'E' 'L' 'F' read as one big-endian word.
   localparam logic [31:0] ELF_MAGIC = 32'h7F454C46;

   // Header field steps.
   localparam logic [3:0] STEP_MAGIC = 4'd0;
   localparam logic [3:0] STEP_CLASS = 4'd1;
   localparam logic [3:0] STEP_DATA  = 4'd2;
   localparam logic [3:0] STEP_TYPE  = 4'd3;
   localparam logic [3:0] STEP_MACH  = 4'd4;
   localparam logic [3:0] STEP_ENTRY = 4'd5;
   localparam logic [3:0] STEP_POFF  = 4'd6;
   localparam logic [3:0] STEP_SOFF  = 4'd7;
   localparam logic [3:0] STEP_HSIZE = 4'd8;
   localparam logic [3:0] STEP_PES   = 4'd9;
   localparam logic [3:0] STEP_PC    = 4'd10;
   localparam logic [3:0] STEP_SES   = 4'd11;
   localparam logic [3:0] STEP_SC    = 4'd12;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       final_chunk;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [16:0] length;
      logic        is_64bit;
      logic        big_endian;
      logic [15:0] machine;
      logic [15:0] file_type;
      logic [15:0] program_count;
      logic [15:0] section_count;
      logic [63:0] entry_address;
   } rsp_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_JUDGE,
      SEQ_IDENT,
      SEQ_HDR,
      SEQ_HCHK,
      SEQ_TBL,
      SEQ_TSIZE,
      SEQ_THELD,
      SEQ_ENT_OFS,
      SEQ_ENT_SZ,
      SEQ_FINAL,
      SEQ_DONE
   } seq_state_type;

   // Request from the sequencer to the field fetch unit.
   typedef struct packed {
      logic       start;
      logic [3:0] nbytes;
      logic       be;
   } fetch_req_type;

   // Field fetch unit completion.
   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } fetch_rsp_type;

   typedef struct packed {
      logic [5:0] addr;
      logic [3:0] nbytes;
   } fld_loc_type;

   // Location and size of a header field for the given step.
   function automatic fld_loc_type hdr_loc(input logic [3:0] step, input logic is64);
      fld_loc_type loc;
      loc = '{addr: 6'd0, nbytes: 4'd1};
      case (step)
         STEP_MAGIC: loc = '{addr: 6'd0, nbytes: 4'd4};
         STEP_CLASS: loc = '{addr: 6'd4, nbytes: 4'd1};
         STEP_DATA:  loc = '{addr: 6'd5, nbytes: 4'd1};
         STEP_TYPE:  loc = '{addr: 6'd16, nbytes: 4'd2};
         STEP_MACH:  loc = '{addr: 6'd18, nbytes: 4'd2};
         STEP_ENTRY: loc = '{addr: 6'd24, nbytes: is64 ? 4'd8 : 4'd4};
         STEP_POFF:  loc = '{addr: is64 ? 6'd32 : 6'd28, nbytes: is64 ? 4'd8 : 4'd4};
         STEP_SOFF:  loc = '{addr: is64 ? 6'd40 : 6'd32, nbytes: is64 ? 4'd8 : 4'd4};
         STEP_HSIZE: loc = '{addr: is64 ? 6'd52 : 6'd40, nbytes: 4'd2};
         STEP_PES:   loc = '{addr: is64 ? 6'd54 : 6'd42, nbytes: 4'd2};
         STEP_PC:    loc = '{addr: is64 ? 6'd56 : 6'd44, nbytes: 4'd2};
         STEP_SES:   loc = '{addr: is64 ? 6'd58 : 6'd46, nbytes: 4'd2};
         STEP_SC:    loc = '{addr: is64 ? 6'd60 : 6'd48, nbytes: 4'd2};
         default:    loc = '{addr: 6'd0, nbytes: 4'd1};
      endcase
      return loc;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/eiec_store.sv =====
// ----------------------------------------------------------------------------
// ELF image extent check byte store
// Single write port, single read port byte memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eiec_store #(
   parameter int unsigned STORE_BYTES = 65536
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(STORE_BYTES)-1:0] wr_addr,
   input  wire logic [7:0]                     wr_data,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(STORE_BYTES)-1:0] rd_addr,
   output logic      [7:0]                     rd_data
);

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/eiec_fetch.sv =====
// ----------------------------------------------------------------------------
// ELF image extent check field fetch unit
// Reads a field of one to eight bytes from the store, one byte per cycle,
// and assembles it in little- or big-endian order.
// ----------------------------------------------------------------------------
`default_nettype none

module eiec_fetch #(
   parameter int unsigned STORE_BYTES = 65536
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire eiec_pkg::fetch_req_type                 fetch_req,
   input  wire logic [$clog2(STORE_BYTES)-1:0]          base_addr,
   output logic                                         rd_en,
   output logic      [$clog2(STORE_BYTES)-1:0]          rd_addr,
   input  wire logic [7:0]                              rd_data,
   output eiec_pkg::fetch_rsp_type                      fetch_rsp
);

   import eiec_pkg::*;

   localparam int unsigned AW = $clog2(STORE_BYTES);

   logic          busy_ff, busy_in;
   logic          pend_ff, pend_in;
   logic [3:0]    issue_ff, issue_in;
   logic [3:0]    cap_ff, cap_in;
   logic [3:0]    nb_ff, nb_in;
   logic          be_ff, be_in;
   logic [AW-1:0] base_ff, base_in;
   logic [63:0]   acc_ff, acc_in;
   logic [3:0]    byte_off;
   logic          last_cap;

   // Big-endian fields are read upward, little-endian ones downward, so the
   // accumulator always shifts the most significant byte in first.
   assign byte_off = be_ff ? issue_ff : (nb_ff - 4'd1 - issue_ff);
   assign rd_en    = busy_ff && (issue_ff < nb_ff);
   assign rd_addr  = base_ff + AW'(byte_off);
   assign last_cap = pend_ff && (cap_ff == (nb_ff - 4'd1));

   assign fetch_rsp.done  = last_cap;
   assign fetch_rsp.value = {acc_ff[55:0], rd_data};

   // Issue and capture control.
   always_comb begin
      busy_in  = busy_ff;
      pend_in  = rd_en;
      issue_in = rd_en ? issue_ff + 4'd1 : issue_ff;
      cap_in   = cap_ff;
      nb_in    = nb_ff;
      be_in    = be_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      if (pend_ff) begin
         acc_in = {acc_ff[55:0], rd_data};
         cap_in = cap_ff + 4'd1;
      end
      if (last_cap) begin
         busy_in = 1'b0;
      end
      if (fetch_req.start) begin
         busy_in  = 1'b1;
         issue_in = 4'd0;
         cap_in   = 4'd0;
         nb_in    = fetch_req.nbytes;
         be_in    = fetch_req.be;
         base_in  = base_addr;
         acc_in   = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
      end
      issue_ff <= issue_in;
      cap_ff   <= cap_in;
      nb_ff    <= nb_in;
      be_ff    <= be_in;
      base_ff  <= base_in;
      acc_ff   <= acc_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/eiec_seq.sv =====
// ----------------------------------------------------------------------------
// ELF image extent check sequencer
// Loads candidate bytes, then steps through the header and both tables with
// the shared field fetch unit and one shared adder for table and segment ends.
// ----------------------------------------------------------------------------
`default_nettype none

module eiec_seq #(
   parameter int unsigned STORE_BYTES = 65536
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire eiec_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output eiec_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [31:0]                         csr_wr_data,
   output logic                                     wr_en,
   output logic      [$clog2(STORE_BYTES)-1:0]      wr_addr,
   output logic      [7:0]                          wr_data,
   output eiec_pkg::fetch_req_type                  fetch_req,
   output logic      [$clog2(STORE_BYTES)-1:0]      fetch_addr,
   input  wire eiec_pkg::fetch_rsp_type             fetch_rsp
);

   import eiec_pkg::*;

   localparam int unsigned AW = $clog2(STORE_BYTES);
   localparam int unsigned HW = AW + 1;

   seq_state_type state_ff, state_in;
   logic [HW-1:0] held_ff, held_in;
   logic          ovf_ff, ovf_in;
   logic          fin_ff, fin_in;
   logic [31:0]   limit_ff, limit_in;
   logic          issued_ff, issued_in;
   logic [3:0]    step_ff, step_in;
   logic [7:0]    cls_ff, cls_in;
   logic          is64_ff, is64_in;
   logic          be_ff, be_in;
   logic [15:0]   ftype_ff, ftype_in;
   logic [15:0]   mach_ff, mach_in;
   logic [63:0]   entry_ff, entry_in;
   logic [31:0]   poff_ff, poff_in;
   logic [31:0]   soff_ff, soff_in;
   logic          off_bad_ff, off_bad_in;
   logic [15:0]   hb_ff, hb_in;
   logic [15:0]   pes_ff, pes_in;
   logic [15:0]   pc_ff, pc_in;
   logic [15:0]   ses_ff, ses_in;
   logic [15:0]   sc_ff, sc_in;
   logic          tbl_ff, tbl_in;
   logic [31:0]   tsize_ff, tsize_in;
   logic [HW-1:0] h_ff, h_in;
   logic [15:0]   idx_ff, idx_in;
   logic [31:0]   fo_ff, fo_in;
   logic [32:0]   furthest_ff, furthest_in;
   logic [2:0]    status_ff, status_in;
   logic [16:0]   len_ff, len_in;
   logic          facts_ff, facts_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic [32:0]   held_x;
   logic [15:0]   cnt;
   logic [15:0]   esz;
   logic [31:0]   toff;
   logic [5:0]    need;
   logic [5:0]    ofs_at;
   logic [5:0]    sz_at;
   logic [6:0]    hsz;
   logic [32:0]   sum;
   logic [32:0]   sum_a;
   logic [32:0]   sum_b;
   logic          val_big;
   fld_loc_type   loc;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != SEQ_IDLE);
   assign held_x    = 33'(held_ff);

   assign wr_en   = accept && (held_ff < HW'(STORE_BYTES));
   assign wr_addr = held_ff[AW-1:0];
   assign wr_data = req_data.data_byte;

   // Per-table geometry.
   assign cnt    = tbl_ff ? sc_ff : pc_ff;
   assign esz    = tbl_ff ? ses_ff : pes_ff;
   assign toff   = tbl_ff ? soff_ff : poff_ff;
   assign need   = is64_ff ? 6'd40 : (tbl_ff ? 6'd24 : 6'd20);
   assign ofs_at = is64_ff ? (tbl_ff ? 6'd24 : 6'd8) : (tbl_ff ? 6'd16 : 6'd4);
   assign sz_at  = is64_ff ? 6'd32 : (tbl_ff ? 6'd20 : 6'd16);
   assign hsz    = is64_ff ? 7'd64 : 7'd52;
   assign loc    = hdr_loc(step_ff, is64_ff);

   // Shared adder: table end in the table check, segment or section end otherwise.
   assign sum_a   = (state_ff == SEQ_THELD) ? 33'(toff) : 33'(fo_ff);
   assign sum_b   = (state_ff == SEQ_THELD) ? 33'(tsize_ff) : 33'(fetch_rsp.value[31:0]);
   assign sum     = sum_a + sum_b;
   assign val_big = fetch_rsp.value > 64'(limit_ff);

   // Field fetch addressing.
   always_comb begin
      fetch_req.be     = be_ff;
      fetch_req.nbytes = loc.nbytes;
      fetch_addr       = AW'(loc.addr);
      if (state_ff == SEQ_IDENT) begin
         fetch_req.be = 1'b1;
      end
      if (state_ff == SEQ_ENT_OFS) begin
         fetch_req.nbytes = is64_ff ? 4'd8 : 4'd4;
         fetch_addr       = AW'(h_ff + HW'(ofs_at));
      end
      if (state_ff == SEQ_ENT_SZ) begin
         fetch_req.nbytes = is64_ff ? 4'd8 : 4'd4;
         fetch_addr       = AW'(h_ff + HW'(sz_at));
      end
      fetch_req.start = !issued_ff &&
                        (state_ff == SEQ_IDENT || state_ff == SEQ_HDR ||
                         state_ff == SEQ_ENT_OFS || state_ff == SEQ_ENT_SZ);
   end

   // Next state and datapath.
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      ovf_in       = ovf_ff;
      fin_in       = fin_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      issued_in    = issued_ff;
      step_in      = step_ff;
      cls_in       = cls_ff;
      is64_in      = is64_ff;
      be_in        = be_ff;
      ftype_in     = ftype_ff;
      mach_in      = mach_ff;
      entry_in     = entry_ff;
      poff_in      = poff_ff;
      soff_in      = soff_ff;
      off_bad_in   = off_bad_ff;
      hb_in        = hb_ff;
      pes_in       = pes_ff;
      pc_in        = pc_ff;
      ses_in       = ses_ff;
      sc_in        = sc_ff;
      tbl_in       = tbl_ff;
      tsize_in     = tsize_ff;
      h_in         = h_ff;
      idx_in       = idx_ff;
      fo_in        = fo_ff;
      furthest_in  = furthest_ff;
      status_in    = status_ff;
      len_in       = len_ff;
      facts_in     = facts_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (fetch_req.start) begin
         issued_in = 1'b1;
      end
      if (fetch_rsp.done) begin
         issued_in = 1'b0;
      end

      case (state_ff)
         // Load one beat into the store, or flag an overflow when it is full; a last beat starts the judgment.
         SEQ_IDLE: begin
            if (accept) begin
               if (held_ff < HW'(STORE_BYTES)) begin
                  held_in = held_ff + HW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  fin_in   = req_data.final_chunk;
                  state_in = SEQ_JUDGE;
               end
            end
         end

         SEQ_JUDGE: begin
            furthest_in = 33'd0;
            facts_in    = 1'b0;
            len_in      = 17'd0;
            step_in     = STEP_MAGIC;
            off_bad_in  = 1'b0;
            if (ovf_ff) begin
               status_in = STAT_OVERFLOW;
               state_in  = SEQ_DONE;
            end else if (held_x < 33'd16) begin
               status_in = fin_ff ? STAT_TRUNC_STR : STAT_NEED_MORE;
               state_in  = SEQ_DONE;
            end else begin
               state_in = SEQ_IDENT;
            end
         end

         // Signature, class and byte order, then a check that the whole header is held.
         SEQ_IDENT: begin
            if (fetch_rsp.done) begin
               step_in = step_ff + 4'd1;
               if (step_ff == STEP_MAGIC) begin
                  if (fetch_rsp.value[31:0] != ELF_MAGIC) begin
                     status_in = STAT_NO_MATCH;
                     state_in  = SEQ_DONE;
                  end
               end else if (step_ff == STEP_CLASS) begin
                  cls_in = fetch_rsp.value[7:0];
               end else begin
                  is64_in = (cls_ff == 8'd2);
                  be_in   = (fetch_rsp.value[7:0] == 8'd2);
                  if ((cls_ff != 8'd1 && cls_ff != 8'd2) ||
                      (fetch_rsp.value[7:0] != 8'd1 && fetch_rsp.value[7:0] != 8'd2)) begin
                     status_in = STAT_NO_MATCH;
                     state_in  = SEQ_DONE;
                  end else if (held_x < ((cls_ff == 8'd2) ? 33'd64 : 33'd52)) begin
                     status_in = fin_ff ? STAT_TRUNC_STR : STAT_NEED_MORE;
                     state_in  = SEQ_DONE;
                  end else begin
                     step_in  = STEP_TYPE;
                     state_in = SEQ_HDR;
                  end
               end
            end
         end

         // Header fields.
         SEQ_HDR: begin
            if (fetch_rsp.done) begin
               step_in = step_ff + 4'd1;
               case (step_ff)
                  STEP_TYPE:  ftype_in = fetch_rsp.value[15:0];
                  STEP_MACH:  mach_in  = fetch_rsp.value[15:0];
                  STEP_ENTRY: entry_in = fetch_rsp.value;
                  STEP_POFF: begin
                     poff_in = fetch_rsp.value[31:0];
                     if (val_big) begin
                        off_bad_in = 1'b1;
                     end
                  end
                  STEP_SOFF: begin
                     soff_in = fetch_rsp.value[31:0];
                     if (val_big) begin
                        off_bad_in = 1'b1;
                     end
                  end
                  STEP_HSIZE: hb_in  = fetch_rsp.value[15:0];
                  STEP_PES:   pes_in = fetch_rsp.value[15:0];
                  STEP_PC:    pc_in  = fetch_rsp.value[15:0];
                  STEP_SES:   ses_in = fetch_rsp.value[15:0];
                  STEP_SC:    sc_in  = fetch_rsp.value[15:0];
                  default:    ftype_in = ftype_ff;
               endcase
               if (step_ff == STEP_SC) begin
                  state_in = SEQ_HCHK;
               end
            end
         end

         SEQ_HCHK: begin
            tbl_in = 1'b0;
            if (hb_ff < 16'(hsz) || off_bad_ff) begin
               status_in = STAT_NO_MATCH;
               state_in  = SEQ_DONE;
            end else begin
               furthest_in = 33'(hb_ff);
               state_in    = SEQ_TBL;
            end
         end

         // Start of a table walk.
         SEQ_TBL: begin
            idx_in = 16'd0;
            if (cnt == 16'd0) begin
               if (tbl_ff) begin
                  state_in = SEQ_FINAL;
               end else begin
                  tbl_in = 1'b1;
               end
            end else if (esz < 16'(need)) begin
               status_in = STAT_NO_MATCH;
               state_in  = SEQ_DONE;
            end else begin
               state_in = SEQ_TSIZE;
            end
         end

         SEQ_TSIZE: begin
            tsize_in = cnt * esz;
            state_in = SEQ_THELD;
         end

         // The whole table must be held.
         SEQ_THELD: begin
            if (sum > held_x) begin
               status_in = fin_ff ? STAT_TRUNC_STR : STAT_NEED_MORE;
               state_in  = SEQ_DONE;
            end else begin
               if (sum > furthest_ff) begin
                  furthest_in = sum;
               end
               h_in     = HW'(toff);
               state_in = SEQ_ENT_OFS;
            end
         end

         SEQ_ENT_OFS: begin
            if (fetch_rsp.done) begin
               fo_in = fetch_rsp.value[31:0];
               if (val_big) begin
                  status_in = STAT_NO_MATCH;
                  state_in  = SEQ_DONE;
               end else begin
                  state_in = SEQ_ENT_SZ;
               end
            end
         end

         // Segment or section end, then on to the next entry.
         SEQ_ENT_SZ: begin
            if (fetch_rsp.done) begin
               if (val_big) begin
                  status_in = STAT_NO_MATCH;
                  state_in  = SEQ_DONE;
               end else begin
                  if (sum > furthest_ff) begin
                     furthest_in = sum;
                  end
                  idx_in = idx_ff + 16'd1;
                  h_in   = h_ff + HW'(esz);
                  if (idx_ff == cnt - 16'd1) begin
                     idx_in = 16'd0;
                     if (tbl_ff) begin
                        state_in = SEQ_FINAL;
                     end else begin
                        tbl_in   = 1'b1;
                        state_in = SEQ_TBL;
                     end
                  end else begin
                     state_in = SEQ_ENT_OFS;
                  end
               end
            end
         end

         SEQ_FINAL: begin
            facts_in = 1'b1;
            state_in = SEQ_DONE;
            if (furthest_ff > held_x) begin
               if (fin_ff) begin
                  status_in = STAT_TRUNC_IMG;
                  len_in    = held_x[16:0];
               end else begin
                  status_in = STAT_NEED_MORE;
               end
            end else begin
               status_in = STAT_MATCHED;
               len_in    = furthest_ff[16:0];
            end
         end

         // Hand the verdict to the output register once it is free.
         SEQ_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.length        = len_ff;
               rsp_in.is_64bit      = facts_ff && is64_ff;
               rsp_in.big_endian    = facts_ff && be_ff;
               rsp_in.machine       = facts_ff ? mach_ff : 16'd0;
               rsp_in.file_type     = facts_ff ? ftype_ff : 16'd0;
               rsp_in.program_count = facts_ff ? pc_ff : 16'd0;
               rsp_in.section_count = facts_ff ? sc_ff : 16'd0;
               rsp_in.entry_address = facts_ff ? entry_ff : 64'd0;
               if (status_ff != STAT_NEED_MORE) begin
                  held_in = '0;
                  ovf_in  = 1'b0;
               end
               state_in = SEQ_IDLE;
            end
         end

         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         held_ff      <= '0;
         ovf_ff       <= 1'b0;
         limit_ff     <= OFFSET_LIMIT_RESET;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         furthest_ff  <= 33'd0;
         idx_ff       <= 16'd0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         ovf_ff       <= ovf_in;
         limit_ff     <= limit_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         furthest_ff  <= furthest_in;
         idx_ff       <= idx_in;
      end
      fin_ff     <= fin_in;
      step_ff    <= step_in;
      cls_ff     <= cls_in;
      is64_ff    <= is64_in;
      be_ff      <= be_in;
      ftype_ff   <= ftype_in;
      mach_ff    <= mach_in;
      entry_ff   <= entry_in;
      poff_ff    <= poff_in;
      soff_ff    <= soff_in;
      off_bad_ff <= off_bad_in;
      hb_ff      <= hb_in;
      pes_ff     <= pes_in;
      pc_ff      <= pc_in;
      ses_ff     <= ses_in;
      sc_ff      <= sc_in;
      tbl_ff     <= tbl_in;
      tsize_ff   <= tsize_in;
      h_ff       <= h_in;
      fo_ff      <= fo_in;
      status_ff  <= status_in;
      len_ff     <= len_in;
      facts_ff   <= facts_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/elf_image_extent_check_top.sv =====
// ----------------------------------------------------------------------------
// ELF image extent check
// Loads a candidate image byte by byte, checks its ELF header and both header
// tables, and reports one verdict with the image length and header facts.
//
// Input channel (req_): one byte per beat with last and final_chunk flags.
// A beat without last is taken while the checker is idle. A beat with last
// starts the judgment, and req_stall stays high until the verdict is in the
// output register. Each field read goes byte by byte through the one store
// read port: first the header fields up to its checks, then two fields per
// entry of each table, its offset and its size. The verdict then passes
// through the DONE state to the output register.
// Result channel (rsp_): one verdict beat per last byte, held in an output
// register. While the receiver stalls, further bytes are still taken; a new
// verdict waits until the previous one has left.
// Configuration (csr_): one write sets the offset limit; write only while idle.
// Reset clears the byte count, the overflow flag, the output valid and sets
// the offset limit to 128 MiB. The byte store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module elf_image_extent_check_top #(
   parameter int unsigned STORE_BYTES = eiec_pkg::STORE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire eiec_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output eiec_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [31:0]       csr_wr_data
);

   import eiec_pkg::*;

   localparam int unsigned AW = $clog2(STORE_BYTES);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [AW-1:0] fetch_addr;
   fetch_req_type fetch_req;
   fetch_rsp_type fetch_rsp;

   // Sequencer and datapath.
   eiec_seq #(.STORE_BYTES(STORE_BYTES)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .fetch_req  (fetch_req),
      .fetch_addr (fetch_addr),
      .fetch_rsp  (fetch_rsp)
   );

   // Shared field fetch unit.
   eiec_fetch #(.STORE_BYTES(STORE_BYTES)) u_fetch (
      .clock    (clock),
      .reset    (reset),
      .fetch_req(fetch_req),
      .base_addr(fetch_addr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .fetch_rsp(fetch_rsp)
   );

   // Candidate byte store.
   eiec_store #(.STORE_BYTES(STORE_BYTES)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // A verdict code is always one of the six defined ones.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= STAT_OVERFLOW)
      else $error("verdict code out of range");

   // Length is zero unless matched or truncated image.
   a_length_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_MATCHED &&
      rsp_data.status != STAT_TRUNC_IMG |-> rsp_data.length == 17'd0)
      else $error("length given with a verdict that carries none");

   // Header facts are zero when the walk never finished.
   a_facts_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_NO_MATCH ||
      rsp_data.status == STAT_TRUNC_STR || rsp_data.status == STAT_OVERFLOW)
      |-> rsp_data.machine == 16'd0 && rsp_data.program_count == 16'd0)
      else $error("header facts given with a failing verdict");

   // Store reads happen only while a judgment is in progress.
   a_fetch_busy: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> req_stall && !wr_en)
      else $error("store read outside of a judgment");

endmodule

`default_nettype wire
